FILE: src/ows_pkg.sv
// Shared types, status codes and CRC helper for the 1-Wire ROM search engine.
// No dependencies; imported by ows_core and one_wire_rom_search_top.
`default_nettype none

package ows_pkg;

  // Request kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_SEND_CMD = 3'd1;
  localparam logic [2:0] ST_CONTINUE = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Bit positions run 1..64; 65 marks a finished pass
  localparam logic [6:0] ROM_BITS     = 7'd64;
  localparam logic [6:0] POS_DONE     = 7'd65;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  // Reflected form of the Dallas CRC8 polynomial x^8 + x^5 + x^4 + 1
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef struct packed {
    logic op;
    logic first_search;
    logic no_presence;
    logic id_bit;
    logic cmp_bit;
  } ows_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_bit;
    logic        direction;
    logic [63:0] rom_value;
    logic [7:0]  crc_value;
    logic        last_device;
    logic [3:0]  family_mark;
  } ows_out_t;

  // Fold one byte into the CRC, lsb first
  function automatic logic [7:0] crc_fold_byte(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    crc  = crc_in;
    data = data_in;
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ data[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFL;
      end else begin
        crc = crc >> 1;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

FILE: src/ows_core.sv
// Search state registers and the per-request decision logic.
// Depends on ows_pkg (request/result types, status codes, CRC helper).
`default_nettype none

module ows_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  ows_pkg::ows_in_t  item,
  output ows_pkg::ows_out_t result
);
  import ows_pkg::*;

  logic [63:0] rom_r, rom_nxt;
  logic [6:0]  ld_r, ld_nxt;
  logic [3:0]  fam_r, fam_nxt;
  logic        lds_r, lds_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  lzp_r, lzp_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        srch_r, srch_nxt;

  logic [2:0]  status;
  logic        send;
  logic        dir;
  logic [5:0]  idx;

  assign idx = pos_r[5:0] - 6'd1;

  always_comb begin
    rom_nxt  = rom_r;
    ld_nxt   = ld_r;
    fam_nxt  = fam_r;
    lds_nxt  = lds_r;
    pos_nxt  = pos_r;
    lzp_nxt  = lzp_r;
    crc_nxt  = crc_r;
    srch_nxt = srch_r;
    status   = ST_IGNORED;
    send     = 1'b0;
    dir      = 1'b0;

    if (item.op == OP_START) begin
      pos_nxt = 7'd1;
      lzp_nxt = '0;
      crc_nxt = '0;
      if (item.first_search || (lds_r && !item.first_search) || item.no_presence) begin
        ld_nxt  = '0;
        fam_nxt = '0;
        lds_nxt = 1'b0;
      end
      if ((lds_r && !item.first_search) || item.no_presence) begin
        srch_nxt = 1'b0;
        status   = ST_NOTFOUND;
      end else begin
        srch_nxt = 1'b1;
        status   = ST_SEND_CMD;
      end
    end else if (srch_r) begin
      if (item.id_bit && item.cmp_bit) begin
        // nobody answered: drop the pass, keep partial ROM and CRC
        ld_nxt   = '0;
        fam_nxt  = '0;
        lds_nxt  = 1'b0;
        srch_nxt = 1'b0;
        status   = ST_NOTFOUND;
      end else begin
        if (item.id_bit != item.cmp_bit) begin
          dir = item.id_bit;
        end else begin
          if (pos_r < ld_r) begin
            dir = rom_r[idx];
          end else begin
            dir = (pos_r == ld_r);
          end
          if (!dir) begin
            lzp_nxt = pos_r;
            if (pos_r < FAMILY_LIMIT) begin
              fam_nxt = pos_r[3:0];
            end
          end
        end
        rom_nxt[idx] = dir;
        send = 1'b1;
        if (pos_r[2:0] == 3'd0) begin
          crc_nxt = crc_fold_byte(crc_r, rom_nxt[{idx[5:3], 3'b000} +: 8]);
        end
        if (pos_r >= ROM_BITS) begin
          srch_nxt = 1'b0;
          pos_nxt  = POS_DONE;
          ld_nxt   = lzp_nxt;
          if (lzp_nxt == 7'd0) begin
            lds_nxt = 1'b1;
          end
          if (rom_nxt[7:0] == 8'd0) begin
            ld_nxt  = '0;
            fam_nxt = '0;
            lds_nxt = 1'b0;
            status  = ST_NOTFOUND;
          end else begin
            status = ST_FOUND;
          end
        end else begin
          pos_nxt = pos_r + 7'd1;
          status  = ST_CONTINUE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r  <= '0;
      ld_r   <= '0;
      fam_r  <= '0;
      lds_r  <= 1'b0;
      pos_r  <= 7'd1;
      lzp_r  <= '0;
      crc_r  <= '0;
      srch_r <= 1'b0;
    end else if (fire) begin
      rom_r  <= rom_nxt;
      ld_r   <= ld_nxt;
      fam_r  <= fam_nxt;
      lds_r  <= lds_nxt;
      pos_r  <= pos_nxt;
      lzp_r  <= lzp_nxt;
      crc_r  <= crc_nxt;
      srch_r <= srch_nxt;
    end
  end

  assign result.status      = status;
  assign result.send_bit    = send;
  assign result.direction   = dir;
  assign result.rom_value   = rom_nxt;
  assign result.crc_value   = crc_nxt;
  assign result.last_device = lds_nxt;
  assign result.family_mark = fam_nxt;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    srch_r |-> (pos_r != 7'd0) && (pos_r <= ROM_BITS))
    else $error("bit position out of range during a pass");

  a_idle_pair_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.op == OP_PAIR && !srch_r) |=> $stable(rom_r) && $stable(crc_r))
    else $error("pair while idle changed search state");

  a_family_range: assert property (@(posedge clk) disable iff (!rst_n)
    fam_r <= 4'd8)
    else $error("family discrepancy beyond family byte");

  a_found_family: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status == ST_FOUND) |=> (rom_r[7:0] != 8'd0) && !srch_r)
    else $error("found reported with zero family byte or pass still open");

endmodule

`default_nettype wire

FILE: src/one_wire_rom_search_top.sv
// A request waits in the input register; its result is held in the result register.
// Throughput: one request per cycle unless out_stall holds a full result register;
// set by the input register, combinational ows_core logic and the result register.
// Reset (rst_n low, synchronous): both registers empty, search idle, ROM code,
// CRC and discrepancy state cleared, bit position back to one.
// Depends on ows_pkg and ows_core.
`default_nettype none

module one_wire_rom_search_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ows_pkg::ows_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ows_pkg::ows_out_t out_data
);
  import ows_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  ows_in_t  in_data_r;
  logic     out_valid_r, out_valid_nxt;
  ows_out_t out_data_r;
  ows_out_t result;
  logic     advance;
  logic     accept;
  logic     fire;

  // Advance the held request whenever the result slot is free or being drained.
  assign advance  = !out_valid_r || !out_stall;
  // Stall the requester only when a held request cannot move on this cycle.
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = in_valid_r && advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load only on a handshake, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  // Decision logic and search state; updates only when the request moves on.
  ows_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fire)
    else $error("result overwritten while stalled");

  a_held_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with room downstream");

endmodule

`default_nettype wire
